/* rtl/mphc_pkg.sv */
// Shared types, codes and constants of the mesh packet header classifier.
package mphc_pkg;

   localparam int unsigned HASH_BYTES = 16;
   localparam int unsigned HOPS_LIMIT = 128;

   localparam logic [15:0] HASH_LEN     = 16'(HASH_BYTES);
   localparam logic [15:0] HDR_FIXED    = 16'd3;
   localparam logic [15:0] PREFIX_BYTES = 16'd4;
   localparam logic [15:0] MIN_FRAME    = 16'd2;
   localparam logic [15:0] COUNT_MAX    = 16'hffff;
   localparam logic [8:0]  HOPS_MAX     = 9'(HOPS_LIMIT);

   localparam logic [1:0] CSR_ANNOUNCE_MIN = 2'd0;
   localparam logic [1:0] CSR_RATCHET      = 2'd1;
   localparam logic [1:0] CSR_ACCESS_MIN   = 2'd2;

   localparam logic [1:0] PTYPE_DATA     = 2'd0;
   localparam logic [1:0] PTYPE_ANNOUNCE = 2'd1;
   localparam logic [1:0] PTYPE_LINKREQ  = 2'd2;
   localparam logic [1:0] PTYPE_PROOF    = 2'd3;

   localparam logic [1:0] DTYPE_SINGLE = 2'd0;
   localparam logic [1:0] DTYPE_GROUP  = 2'd1;
   localparam logic [1:0] DTYPE_PLAIN  = 2'd2;
   localparam logic [1:0] DTYPE_LINK   = 2'd3;

   localparam logic [7:0] CTX_RESOURCE   = 8'h01;
   localparam logic [7:0] CTX_RES_PROOF  = 8'h05;
   localparam logic [7:0] CTX_CACHE_REQ  = 8'h08;
   localparam logic [7:0] CTX_KEEPALIVE  = 8'hfa;

   typedef enum logic [1:0] {
      STATUS_MATCHED   = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_NO_MATCH  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      KIND_UNKNOWN   = 3'd0,
      KIND_DATA      = 3'd1,
      KIND_ADVERT    = 3'd2,
      KIND_CONTROL   = 3'd3,
      KIND_ENCRYPTED = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      DEPTH_UNKNOWN   = 2'd0,
      DEPTH_HEADER    = 2'd1,
      DEPTH_PAYLOAD   = 2'd2,
      DEPTH_MALFORMED = 2'd3
   } depth_type;

   typedef struct packed {
      logic [15:0] count;
      logic [7:0]  shim;
      logic [7:0]  flags;
      logic [7:0]  hops;
      logic [7:0]  context_byte;
      logic [31:0] dest_prefix;
      logic [31:0] src_prefix;
      logic        target;
      logic        truncated;
   } frame_rec_type;

   typedef struct packed {
      status_type  status;
      kind_type    kind;
      depth_type   depth;
      logic        encrypted;
      logic [31:0] packed_flags;
      logic [7:0]  hop_count;
      logic [31:0] destination_prefix;
      logic [31:0] source_prefix;
      logic [15:0] payload_start;
      logic [15:0] payload_size;
   } result_type;

endpackage

/* rtl/mphc_front.sv */
// Front end: takes frame bytes, tracks header fields and emits one record per frame.
module mphc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   input  logic                   frame_truncated,
   input  logic                   target_protocol,
   output logic                   rec_push,
   output mphc_pkg::frame_rec_type rec
);
   import mphc_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [7:0]  shim_ff, shim_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  hops_ff, hops_in;
   logic [7:0]  ctx_ff, ctx_in;
   logic [31:0] dest_ff, dest_in;
   logic [31:0] src_ff, src_in;
   logic        target_ff, target_in;

   logic        two;
   logic [15:0] dest_off;
   logic [15:0] ctx_off;

   always_comb begin
      count_in  = count_ff;
      shim_in   = shim_ff;
      flags_in  = flags_ff;
      hops_in   = hops_ff;
      ctx_in    = ctx_ff;
      dest_in   = dest_ff;
      src_in    = src_ff;
      target_in = target_ff;
      rec_push  = 1'b0;
      rec       = '0;
      two       = (count_ff >= MIN_FRAME) && flags_ff[6];
      dest_off  = two ? HDR_FIXED + HASH_LEN : HDR_FIXED;
      ctx_off   = dest_off + HASH_LEN;
      if (accept) begin
         if (count_ff == 16'd0) begin
            target_in = target_protocol;
            shim_in   = data_byte;
         end else if (count_ff == 16'd1) begin
            flags_in = data_byte;
         end else if (count_ff == 16'd2) begin
            hops_in = data_byte;
         end else begin
            if (two && count_ff < HDR_FIXED + PREFIX_BYTES)
               src_in = {src_ff[23:0], data_byte};
            if (count_ff >= dest_off && count_ff < dest_off + PREFIX_BYTES)
               dest_in = {dest_ff[23:0], data_byte};
            if (count_ff == ctx_off)
               ctx_in = data_byte;
         end
         if (count_ff != COUNT_MAX)
            count_in = count_ff + 16'd1;
         if (last_byte) begin
            rec_push         = 1'b1;
            rec.count        = count_in;
            rec.shim         = shim_in;
            rec.flags        = flags_in;
            rec.hops         = hops_in;
            rec.context_byte = ctx_in;
            rec.dest_prefix  = dest_in;
            rec.src_prefix   = src_in;
            rec.target       = target_in;
            rec.truncated    = frame_truncated;
            count_in  = '0;
            shim_in   = '0;
            flags_in  = '0;
            hops_in   = '0;
            ctx_in    = '0;
            dest_in   = '0;
            src_in    = '0;
            target_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         shim_ff   <= '0;
         flags_ff  <= '0;
         hops_ff   <= '0;
         ctx_ff    <= '0;
         dest_ff   <= '0;
         src_ff    <= '0;
         target_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         shim_ff   <= shim_in;
         flags_ff  <= flags_in;
         hops_ff   <= hops_in;
         ctx_ff    <= ctx_in;
         dest_ff   <= dest_in;
         src_ff    <= src_in;
         target_ff <= target_in;
      end
   end

endmodule

/* rtl/mphc_frame_queue.sv */
// Two-entry queue of frame records between the front and back ends.
module mphc_frame_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mphc_pkg::frame_rec_type push_rec,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output mphc_pkg::frame_rec_type head
);
   import mphc_pkg::*;

   frame_rec_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;

   assign full  = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop)
         fill_in = fill_ff + 2'd1;
      else if (pop && !push)
         fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

/* rtl/mphc_back.sv */
// Back end: control registers, frame classification and the result register.
module mphc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [1:0]              csr_index,
   input  logic [9:0]              csr_data,
   input  logic                    in_empty,
   input  mphc_pkg::frame_rec_type in_head,
   output logic                    in_pop,
   input  logic                    out_pop,
   output logic                    out_empty,
   output mphc_pkg::result_type    out_res
);
   import mphc_pkg::*;

   logic [9:0] announce_min_ff;
   logic [7:0] ratchet_extra_ff;
   logic [7:0] access_min_ff;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   logic        two;
   logic [15:0] logical;
   logic [15:0] physical;
   logic [15:0] need_access;
   logic [15:0] need_announce;
   logic [1:0]  ptype;
   logic [1:0]  dtype;

   function automatic logic payload_clear(input logic [1:0] pt, input logic [1:0] dt,
                                          input logic [7:0] ctx);
      logic clr;
      clr = 1'b0;
      if (pt == PTYPE_ANNOUNCE || pt == PTYPE_LINKREQ || dt == DTYPE_PLAIN)
         clr = 1'b1;
      else if (pt == PTYPE_PROOF && (ctx == CTX_RES_PROOF || dt == DTYPE_LINK))
         clr = 1'b1;
      else if (ctx == CTX_RESOURCE || ctx == CTX_CACHE_REQ || ctx == CTX_KEEPALIVE)
         clr = 1'b1;
      return clr;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         announce_min_ff  <= 10'd148;
         ratchet_extra_ff <= 8'd32;
         access_min_ff    <= 8'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANNOUNCE_MIN: announce_min_ff  <= csr_data;
            CSR_RATCHET:      ratchet_extra_ff <= csr_data[7:0];
            CSR_ACCESS_MIN:   access_min_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      two           = in_head.flags[6];
      logical       = two ? HDR_FIXED + HASH_LEN + HASH_LEN : HDR_FIXED + HASH_LEN;
      physical      = logical + 16'd1;
      need_access   = 16'd1 + HDR_FIXED + HASH_LEN + {8'd0, access_min_ff};
      need_announce = {6'd0, announce_min_ff}
                    + (in_head.flags[5] ? {8'd0, ratchet_extra_ff} : 16'd0);
      ptype         = in_head.flags[1:0];
      dtype         = in_head.flags[3:2];

      res_in        = '0;
      res_in.status = STATUS_MATCHED;
      res_in.kind   = KIND_UNKNOWN;
      res_in.depth  = DEPTH_UNKNOWN;
      if (!in_head.target) begin
         res_in.status = STATUS_NO_MATCH;
      end else if (in_head.count < MIN_FRAME) begin
         res_in.status = STATUS_MALFORMED;
         res_in.depth  = DEPTH_MALFORMED;
      end else begin
         res_in.packed_flags  = {8'd0, in_head.shim, 16'd0};
         res_in.payload_start = 16'd1;
         res_in.payload_size  = in_head.count - 16'd1;
         res_in.depth         = DEPTH_HEADER;
         res_in.kind          = KIND_DATA;
         if (in_head.shim[0]) begin
            // split radio frame
            if (in_head.truncated) begin
               res_in.status = STATUS_MALFORMED;
               res_in.depth  = DEPTH_MALFORMED;
            end
         end else begin
            res_in.packed_flags[7:0] = in_head.flags;
            if (in_head.flags[7]) begin
               // access-code protected frame
               if (in_head.count < need_access || in_head.truncated) begin
                  res_in.status = STATUS_MALFORMED;
                  res_in.depth  = DEPTH_MALFORMED;
               end else begin
                  res_in.kind      = KIND_ENCRYPTED;
                  res_in.encrypted = 1'b1;
               end
            end else if (in_head.count < physical ||
                         {1'b0, in_head.hops} >= HOPS_MAX) begin
               res_in.status = STATUS_MALFORMED;
               res_in.depth  = DEPTH_MALFORMED;
            end else begin
               res_in.packed_flags[31:24] = logical[7:0];
               res_in.packed_flags[15:8]  = in_head.context_byte;
               res_in.hop_count           = in_head.hops;
               res_in.destination_prefix  = in_head.dest_prefix;
               res_in.source_prefix       = two ? in_head.src_prefix : 32'd0;
               res_in.payload_start       = physical;
               res_in.payload_size        = in_head.count - physical;
               if (ptype == PTYPE_ANNOUNCE) begin
                  res_in.kind = KIND_ADVERT;
                  if (dtype == DTYPE_SINGLE && res_in.payload_size >= need_announce)
                     res_in.depth = DEPTH_PAYLOAD;
               end else if (ptype == PTYPE_LINKREQ || ptype == PTYPE_PROOF) begin
                  res_in.kind = KIND_CONTROL;
               end
               if (!payload_clear(ptype, dtype, in_head.context_byte)) begin
                  res_in.kind      = KIND_ENCRYPTED;
                  res_in.encrypted = 1'b1;
               end
               if (in_head.truncated) begin
                  res_in.status = STATUS_MALFORMED;
                  res_in.depth  = DEPTH_MALFORMED;
               end
            end
         end
      end
   end

   assign in_pop    = !in_empty && (!valid_ff || out_pop);
   assign out_empty = !valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_pop)
         valid_in = 1'b1;
      else if (out_pop)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_pop)
         res_ff <= res_in;
   end

endmodule

/* rtl/mesh_packet_header_classifier.sv */
// Top level of the mesh packet header classifier.
//
// Frame bytes are pushed on the req_ side, one beat per byte; req_last_byte
// marks the final byte and req_frame_truncated is sampled with it, while
// req_target_protocol is sampled with the first byte. A beat is taken at a
// clock edge with req_push high and req_full low.
// Each frame gives one result beat on the rsp_ side: it is valid while
// rsp_empty is low and is taken at an edge with rsp_pop high.
// Bytes are taken one per cycle while req_full is low. The last byte's
// record enters a two-entry frame queue and then the result register; one
// result per cycle can drain, so frames as short as one byte stream at full
// rate. If the receiver stalls, the result register and the frame queue
// fill and req_full rises; bytes of the frame in progress are held off until
// a slot frees. Control registers are written through
// csr_write/csr_index/csr_data; the user writes them only with the block
// idle, which the block does not enforce. Reset (synchronous) clears the
// frame state and both queues and loads the register defaults 148, 32 and 1.
module mesh_packet_header_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_frame_truncated,
   input  logic        req_target_protocol,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_packet_kind,
   output logic [1:0]  rsp_decode_depth,
   output logic        rsp_encrypted,
   output logic [31:0] rsp_packed_flags,
   output logic [7:0]  rsp_hop_count,
   output logic [31:0] rsp_destination_prefix,
   output logic [31:0] rsp_source_prefix,
   output logic [15:0] rsp_payload_start,
   output logic [15:0] rsp_payload_size,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import mphc_pkg::*;

   logic          accept;
   logic          rec_push;
   frame_rec_type rec;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   frame_rec_type q_head;
   result_type    res;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   mphc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .last_byte       (req_last_byte),
      .frame_truncated (req_frame_truncated),
      .target_protocol (req_target_protocol),
      .rec_push        (rec_push),
      .rec             (rec)
   );

   mphc_frame_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   mphc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_empty  (q_empty),
      .in_head   (q_head),
      .in_pop    (q_pop),
      .out_pop   (rsp_pop),
      .out_empty (rsp_empty),
      .out_res   (res)
   );

   assign rsp_status             = res.status;
   assign rsp_packet_kind        = res.kind;
   assign rsp_decode_depth       = res.depth;
   assign rsp_encrypted          = res.encrypted;
   assign rsp_packed_flags       = res.packed_flags;
   assign rsp_hop_count          = res.hop_count;
   assign rsp_destination_prefix = res.destination_prefix;
   assign rsp_source_prefix      = res.source_prefix;
   assign rsp_payload_start      = res.payload_start;
   assign rsp_payload_size       = res.payload_size;

endmodule

/* bench/mesh_packet_header_classifier_tb.sv */
// Self-checking bench for the mesh packet header classifier: directed frames, then random frames.
`timescale 1ns / 100ps

module mesh_packet_header_classifier_tb;
   import mphc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500_000;
   localparam int unsigned PHASE_BYTES  = 40;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct {
      bit          tgt;
      logic [7:0]  shim;
      logic [7:0]  flags;
      logic [7:0]  hops;
      logic [7:0]  ctx;
      int unsigned len;
      bit          trunc;
      bit          fixed_exp;
      status_type  st;
      kind_type    kd;
      depth_type   dp;
   } frame_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        req_frame_truncated;
   logic        req_target_protocol;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_packet_kind;
   logic [1:0]  rsp_decode_depth;
   logic        rsp_encrypted;
   logic [31:0] rsp_packed_flags;
   logic [7:0]  rsp_hop_count;
   logic [31:0] rsp_destination_prefix;
   logic [31:0] rsp_source_prefix;
   logic [15:0] rsp_payload_start;
   logic [15:0] rsp_payload_size;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [9:0]  csr_data;

   // classifier registers as last written
   int unsigned cfg_announce_min;
   int unsigned cfg_ratchet;
   int unsigned cfg_access_min;

   // frame being absorbed
   logic [15:0] frm_count;
   logic [7:0]  frm_shim;
   logic [7:0]  frm_flags;
   logic [7:0]  frm_hops;
   logic [7:0]  frm_ctx;
   logic [31:0] frm_dest;
   logic [31:0] frm_src;
   logic        frm_target;

   result_type  expected_verdicts[$];
   logic [7:0]  frame_bytes[$];
   bit          frame_tgt;
   bit          frame_trunc;
   int unsigned mismatch_count;
   int unsigned bytes_sent;
   int unsigned cycle_count;
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned pop_hold_left;
   int unsigned idle_pcts[4]  = '{0, 67, 0, 29};
   int unsigned stall_pcts[4] = '{0, 0, 67, 29};

   frame_row_type dir_rows[25] = '{
      '{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 24, 1'b0, 1'b1,
        STATUS_NO_MATCH, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b1,
        STATUS_MALFORMED, KIND_UNKNOWN, DEPTH_MALFORMED},
      '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 2, 1'b0, 1'b1,
        STATUS_MALFORMED, KIND_DATA, DEPTH_MALFORMED},
      '{1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 10, 1'b0, 1'b1,
        STATUS_MATCHED, KIND_DATA, DEPTH_HEADER},
      '{1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 7, 1'b1, 1'b1,
        STATUS_MALFORMED, KIND_DATA, DEPTH_MALFORMED},
      '{1'b1, 8'h00, 8'h80, 8'h00, 8'h00, 21, 1'b0, 1'b1,
        STATUS_MATCHED, KIND_ENCRYPTED, DEPTH_HEADER},
      '{1'b1, 8'h00, 8'hff, 8'h00, 8'h00, 20, 1'b0, 1'b1,
        STATUS_MALFORMED, KIND_DATA, DEPTH_MALFORMED},
      '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 20, 1'b0, 1'b1,
        STATUS_MATCHED, KIND_ENCRYPTED, DEPTH_HEADER},
      '{1'b1, 8'h00, 8'h08, 8'h80, 8'h00, 30, 1'b0, 1'b1,
        STATUS_MALFORMED, KIND_DATA, DEPTH_MALFORMED},
      '{1'b1, 8'h00, 8'h08, 8'h7f, 8'h00, 25, 1'b0, 1'b1,
        STATUS_MATCHED, KIND_DATA, DEPTH_HEADER},
      '{1'b1, 8'h00, 8'h40, 8'h00, 8'h00, 35, 1'b0, 1'b1,
        STATUS_MALFORMED, KIND_DATA, DEPTH_MALFORMED},
      '{1'b1, 8'h02, 8'h41, 8'h03, 8'h00, 184, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h21, 8'h01, 8'h00, 200, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h21, 8'h01, 8'h00, 199, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h02, 8'h00, 8'h00, 40, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h03, 8'h00, 8'h05, 40, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h0f, 8'h00, 8'h00, 40, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h03, 8'h00, 8'h00, 40, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h04, 8'h00, 8'h01, 30, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h00, 8'h00, 8'h08, 30, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h04, 8'h00, 8'hfa, 30, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h08, 8'h00, 8'h00, 40, 1'b1, 1'b1,
        STATUS_MALFORMED, KIND_DATA, DEPTH_MALFORMED},
      '{1'b1, 8'h00, 8'h7c, 8'h05, 8'hff, 50, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'h00, 8'h08, 8'h00, 8'h00, 48, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN},
      '{1'b1, 8'hfe, 8'h48, 8'h7f, 8'hff, 36, 1'b0, 1'b0,
        STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN}
   };

   mesh_packet_header_classifier dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_data_byte          (req_data_byte),
      .req_last_byte          (req_last_byte),
      .req_frame_truncated    (req_frame_truncated),
      .req_target_protocol    (req_target_protocol),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_status             (rsp_status),
      .rsp_packet_kind        (rsp_packet_kind),
      .rsp_decode_depth       (rsp_decode_depth),
      .rsp_encrypted          (rsp_encrypted),
      .rsp_packed_flags       (rsp_packed_flags),
      .rsp_hop_count          (rsp_hop_count),
      .rsp_destination_prefix (rsp_destination_prefix),
      .rsp_source_prefix      (rsp_source_prefix),
      .rsp_payload_start      (rsp_payload_start),
      .rsp_payload_size       (rsp_payload_size),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_frame_state();
      frm_count  = '0;
      frm_shim   = '0;
      frm_flags  = '0;
      frm_hops   = '0;
      frm_ctx    = '0;
      frm_dest   = '0;
      frm_src    = '0;
      frm_target = 1'b0;
   endfunction

   function automatic void absorb_header_byte(input logic [7:0] b, input logic tgt);
      int unsigned p;
      int unsigned dest_off;
      int unsigned ctx_off;
      bit          two;
      p        = frm_count;
      two      = (p >= 2) && frm_flags[6];
      dest_off = two ? 3 + HASH_BYTES : 3;
      ctx_off  = dest_off + HASH_BYTES;
      if (p == 0) begin
         frm_target = tgt;
         frm_shim   = b;
      end else if (p == 1) begin
         frm_flags = b;
      end else if (p == 2) begin
         frm_hops = b;
      end else begin
         if (two && p < 7)
            frm_src = {frm_src[23:0], b};
         if (p >= dest_off && p < dest_off + 4)
            frm_dest = {frm_dest[23:0], b};
         if (p == ctx_off)
            frm_ctx = b;
      end
      if (frm_count != COUNT_MAX)
         frm_count = frm_count + 16'd1;
   endfunction

   function automatic result_type classify_frame(input logic trunc);
      result_type  r;
      int unsigned cnt;
      int unsigned logical;
      int unsigned physical;
      int unsigned need;
      bit          two;
      bit          clear_text;
      logic [1:0]  ptype;
      logic [1:0]  dtype;
      r   = '0;
      cnt = frm_count;
      if (!frm_target) begin
         r.status = STATUS_NO_MATCH;
         return r;
      end
      if (cnt < 2) begin
         r.status = STATUS_MALFORMED;
         r.depth  = DEPTH_MALFORMED;
         return r;
      end
      r.packed_flags  = {8'h00, frm_shim, 16'h0000};
      r.payload_start = 16'd1;
      r.payload_size  = 16'(cnt - 1);
      r.depth         = DEPTH_HEADER;
      r.kind          = KIND_DATA;
      // split frame: only the shim is trusted
      if (frm_shim[0]) begin
         if (trunc) begin
            r.status = STATUS_MALFORMED;
            r.depth  = DEPTH_MALFORMED;
         end
         return r;
      end
      r.packed_flags[7:0] = frm_flags;
      // access-code frame: header is opaque
      if (frm_flags[7]) begin
         need = 1 + 3 + HASH_BYTES + cfg_access_min;
         if (cnt < need || trunc) begin
            r.status = STATUS_MALFORMED;
            r.depth  = DEPTH_MALFORMED;
         end else begin
            r.kind      = KIND_ENCRYPTED;
            r.encrypted = 1'b1;
         end
         return r;
      end
      two      = frm_flags[6];
      logical  = 3 + HASH_BYTES * (two ? 2 : 1);
      physical = 1 + logical;
      if (cnt < physical || frm_hops >= HOPS_LIMIT) begin
         r.status = STATUS_MALFORMED;
         r.depth  = DEPTH_MALFORMED;
         return r;
      end
      ptype                 = frm_flags[1:0];
      dtype                 = frm_flags[3:2];
      r.packed_flags[15:8]  = frm_ctx;
      r.packed_flags[31:24] = logical[7:0];
      r.hop_count           = frm_hops;
      r.destination_prefix  = frm_dest;
      r.source_prefix       = two ? frm_src : 32'h0;
      r.payload_start       = 16'(physical);
      r.payload_size        = 16'(cnt - physical);
      if (ptype == PTYPE_ANNOUNCE) begin
         r.kind = KIND_ADVERT;
         need   = cfg_announce_min + (frm_flags[5] ? cfg_ratchet : 0);
         if (dtype == DTYPE_SINGLE && r.payload_size >= need)
            r.depth = DEPTH_PAYLOAD;
      end else if (ptype == PTYPE_LINKREQ || ptype == PTYPE_PROOF) begin
         r.kind = KIND_CONTROL;
      end
      if (ptype == PTYPE_ANNOUNCE || ptype == PTYPE_LINKREQ || dtype == DTYPE_PLAIN)
         clear_text = 1'b1;
      else if (ptype == PTYPE_PROOF && (frm_ctx == CTX_RES_PROOF || dtype == DTYPE_LINK))
         clear_text = 1'b1;
      else
         clear_text = frm_ctx == CTX_RESOURCE || frm_ctx == CTX_CACHE_REQ ||
                      frm_ctx == CTX_KEEPALIVE;
      if (!clear_text) begin
         r.kind      = KIND_ENCRYPTED;
         r.encrypted = 1'b1;
      end
      if (trunc) begin
         r.status = STATUS_MALFORMED;
         r.depth  = DEPTH_MALFORMED;
      end
      return r;
   endfunction

   function automatic void build_frame(input logic [7:0] shim, input logic [7:0] flags,
                                       input logic [7:0] hops, input logic [7:0] ctx,
                                       input int unsigned len);
      int unsigned ctx_pos;
      logic [7:0]  b;
      ctx_pos = flags[6] ? 3 + 2 * HASH_BYTES : 3 + HASH_BYTES;
      frame_bytes.delete();
      for (int unsigned i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (i == 0)
            b = shim;
         else if (i == 1)
            b = flags;
         else if (i == 2)
            b = hops;
         else if (i == ctx_pos)
            b = ctx;
         frame_bytes.push_back(b);
      end
   endfunction

   function automatic void make_random_frame();
      int unsigned choice;
      int unsigned hdr;
      int unsigned need;
      int unsigned len;
      int          offs;
      logic [7:0]  shim;
      logic [7:0]  flags;
      logic [7:0]  hops;
      logic [7:0]  ctx;
      choice      = $urandom_range(99);
      frame_tgt   = $urandom_range(19) != 0;
      frame_trunc = $urandom_range(9) == 0;
      shim        = 8'($urandom);
      if ($urandom_range(9) != 0)
         shim[0] = 1'b0;
      flags = 8'($urandom);
      if ($urandom_range(4) != 0)
         flags[7] = 1'b0;
      hops = 8'($urandom_range(127));
      if ($urandom_range(9) == 0)
         hops = 8'($urandom_range(255, 128));
      case ($urandom_range(5))
         0: ctx = 8'h00;
         1: ctx = CTX_RESOURCE;
         2: ctx = CTX_RES_PROOF;
         3: ctx = CTX_CACHE_REQ;
         4: ctx = CTX_KEEPALIVE;
         default: ctx = 8'($urandom);
      endcase
      hdr = 1 + 3 + HASH_BYTES * (flags[6] ? 2 : 1);
      if (choice < 15) begin
         len = $urandom_range(hdr + 2, 1);
      end else if (flags[7]) begin
         len = 1 + 3 + HASH_BYTES + cfg_access_min + $urandom_range(5) - 2;
      end else if (flags[1:0] == PTYPE_ANNOUNCE) begin
         need = cfg_announce_min + (flags[5] ? cfg_ratchet : 0);
         if (need <= 200 && $urandom_range(1) == 1) begin
            offs = int'(need) + int'($urandom_range(4)) - 2;
            len  = hdr + ((offs < 0) ? 0 : offs);
         end else begin
            len = hdr + $urandom_range(24);
         end
      end else begin
         len = hdr + $urandom_range(24);
      end
      build_frame(shim, flags, hops, ctx, len);
   endfunction

   task automatic send_frame(input bit use_fixed, input status_type fs,
                             input kind_type fk, input depth_type fd);
      int unsigned n;
      logic        tgt;
      result_type  verdict;
      n = frame_bytes.size();
      for (int unsigned i = 0; i < n; i++) begin
         while ($urandom_range(99) < req_idle_pct) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
         tgt = (i == 0) ? frame_tgt : 1'($urandom);
         @(negedge clock);
         req_push            <= 1'b1;
         req_data_byte       <= frame_bytes[i];
         req_last_byte       <= (i == n - 1);
         req_frame_truncated <= (i == n - 1) ? frame_trunc : 1'($urandom);
         req_target_protocol <= tgt;
         @(posedge clock);
         while (req_full)
            @(posedge clock);
         absorb_header_byte(frame_bytes[i], tgt);
         bytes_sent++;
      end
      verdict = classify_frame(frame_trunc);
      if (use_fixed) begin
         verdict.status = fs;
         verdict.kind   = fk;
         verdict.depth  = fd;
      end
      expected_verdicts.push_back(verdict);
      clear_frame_state();
   endtask

   task automatic drain_verdicts();
      @(negedge clock);
      req_push <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [9:0] ann, input logic [7:0] rat,
                             input logic [7:0] acc);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_ANNOUNCE_MIN;
      csr_data  <= ann;
      @(negedge clock);
      csr_index <= CSR_RATCHET;
      csr_data  <= {2'b00, rat};
      @(negedge clock);
      csr_index <= CSR_ACCESS_MIN;
      csr_data  <= {2'b00, acc};
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_announce_min = ann;
      cfg_ratchet      = rat;
      cfg_access_min   = acc;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (pop_hold_left > 0) begin
         rsp_pop <= 1'b0;
         pop_hold_left = pop_hold_left - 1;
      end else begin
         rsp_pop <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   always @(posedge clock) begin : verdict_check
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_verdicts.size() == 0) begin
            $error("result beat with no frame outstanding");
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("packet_kind", want.kind, rsp_packet_kind);
            compare_field("decode_depth", want.depth, rsp_decode_depth);
            compare_field("encrypted", want.encrypted, rsp_encrypted);
            compare_field("packed_flags", want.packed_flags, rsp_packed_flags);
            compare_field("hop_count", want.hop_count, rsp_hop_count);
            compare_field("destination_prefix", want.destination_prefix,
                          rsp_destination_prefix);
            compare_field("source_prefix", want.source_prefix, rsp_source_prefix);
            compare_field("payload_start", want.payload_start, rsp_payload_start);
            compare_field("payload_size", want.payload_size, rsp_payload_size);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_push            = 1'b0;
      req_data_byte       = '0;
      req_last_byte       = 1'b0;
      req_frame_truncated = 1'b0;
      req_target_protocol = 1'b0;
      rsp_pop             = 1'b0;
      csr_write           = 1'b0;
      csr_index           = CSR_ANNOUNCE_MIN;
      csr_data            = '0;
      mismatch_count      = 0;
      bytes_sent          = 0;
      cycle_count         = 0;
      req_idle_pct        = 0;
      rsp_stall_pct       = 0;
      pop_hold_left       = 0;
      cfg_announce_min    = 148;
      cfg_ratchet         = 32;
      cfg_access_min      = 1;
      clear_frame_state();

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed frames on reset defaults, full rate
      foreach (dir_rows[k]) begin
         build_frame(dir_rows[k].shim, dir_rows[k].flags, dir_rows[k].hops,
                     dir_rows[k].ctx, dir_rows[k].len);
         frame_tgt   = dir_rows[k].tgt;
         frame_trunc = dir_rows[k].trunc;
         send_frame(dir_rows[k].fixed_exp, dir_rows[k].st, dir_rows[k].kd, dir_rows[k].dp);
      end
      drain_verdicts();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_regs(10'd0, 8'd0, 8'd0);
            1: write_regs(10'd1023, 8'd255, 8'd255);
            2: write_regs(10'($urandom_range(60)), 8'($urandom_range(40)),
                          8'($urandom_range(30)));
            default: write_regs(10'($urandom), 8'($urandom), 8'($urandom));
         endcase
         req_idle_pct  = idle_pcts[ph];
         rsp_stall_pct = stall_pcts[ph];
         begin : phase_frames
            int unsigned goal;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) begin
               make_random_frame();
               send_frame(1'b0, STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN);
            end
         end
         drain_verdicts();
      end

      // receiver holds off while short frames keep coming: queue fills, input stalls
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      pop_hold_left = 300;
      for (int f = 0; f < 40; f++) begin
         build_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     $urandom_range(3, 1));
         frame_tgt   = $urandom_range(3) != 0;
         frame_trunc = 1'($urandom);
         send_frame(1'b0, STATUS_MATCHED, KIND_UNKNOWN, DEPTH_UNKNOWN);
      end
      drain_verdicts();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
